[rtl/core/segi_pkg.sv]
// shared constants for the segment intersection block
`timescale 1ns / 1ps
`default_nettype none

package segi_pkg;

    // width of the reported crossing coordinates
    localparam int OUT_BITS = 24;

    // result status codes
    localparam logic [1:0] ST_FOUND   = 2'd0;
    localparam logic [1:0] ST_ZERO    = 2'd1;
    localparam logic [1:0] ST_NOCROSS = 2'd2;
    localparam logic [1:0] ST_OUTSIDE = 2'd3;

endpackage

`default_nettype wire

[rtl/core/segi_if.sv]
// valid/ready channel interfaces for segment pairs and intersection results
`timescale 1ns / 1ps
`default_nettype none

interface segi_in_if #(
    parameter int COORD_BITS = 16
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] point_a_x;
    logic signed [COORD_BITS-1:0] point_a_y;
    logic signed [COORD_BITS-1:0] point_b_x;
    logic signed [COORD_BITS-1:0] point_b_y;
    logic signed [COORD_BITS-1:0] point_c_x;
    logic signed [COORD_BITS-1:0] point_c_y;
    logic signed [COORD_BITS-1:0] point_d_x;
    logic signed [COORD_BITS-1:0] point_d_y;

    modport source (
        output valid, point_a_x, point_a_y, point_b_x, point_b_y,
               point_c_x, point_c_y, point_d_x, point_d_y,
        input  ready
    );
    modport sink (
        input  valid, point_a_x, point_a_y, point_b_x, point_b_y,
               point_c_x, point_c_y, point_d_x, point_d_y,
        output ready
    );
endinterface

interface segi_out_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 hit;
    logic [1:0]                           status;
    logic signed [segi_pkg::OUT_BITS-1:0] cross_x;
    logic signed [segi_pkg::OUT_BITS-1:0] cross_y;

    modport source (
        output valid, hit, status, cross_x, cross_y,
        input  ready
    );
    modport sink (
        input  valid, hit, status, cross_x, cross_y,
        output ready
    );
endinterface

`default_nettype wire

[rtl/core/segi_muldiv.sv]
// pipelined exact floor(num * mag / den) with signed round-to-nearest offset
`timescale 1ns / 1ps
`default_nettype none

module segi_muldiv #(
    parameter int NB = 36,
    parameter int MB = 24
) (
    input  wire                  i_clk,
    input  wire                  i_en,
    input  wire [NB-1:0]         i_num,
    input  wire [NB-1:0]         i_den,
    input  wire [MB-1:0]         i_mag,
    input  wire                  i_neg,
    output logic signed [MB:0]   o_off
);

    logic [NB-1:0] r_rem [MB];
    logic [NB-1:0] r_num [MB];
    logic [NB-1:0] r_den [MB];
    logic [MB-1:0] r_q   [MB];
    logic [MB-1:0] r_mag [MB];
    logic          r_neg [MB];
    logic signed [MB:0] r_off;

    for (genvar i = 0; i < MB; i++) begin : g_stage
        logic [NB-1:0] p_rem, p_num, p_den;
        logic [MB-1:0] p_q, p_mag;
        logic          p_neg;
        logic [NB+1:0] t, den1, den2;
        logic [MB-1:0] n_q;
        logic [NB-1:0] n_rem;

        if (i == 0) begin : g_first
            assign p_rem = '0;
            assign p_num = i_num;
            assign p_den = i_den;
            assign p_q   = '0;
            assign p_mag = i_mag;
            assign p_neg = i_neg;
        end else begin : g_next
            assign p_rem = r_rem[i-1];
            assign p_num = r_num[i-1];
            assign p_den = r_den[i-1];
            assign p_q   = r_q[i-1];
            assign p_mag = r_mag[i-1];
            assign p_neg = r_neg[i-1];
        end

        // r stays below den, so 2r + num stays below 3 den
        always_comb begin
            den1 = {2'b00, p_den};
            den2 = {1'b0, p_den, 1'b0};
            t    = {1'b0, p_rem, 1'b0}
                 + (p_mag[MB-1-i] ? {2'b00, p_num} : {(NB+2){1'b0}});
            if (t >= den2) begin
                n_rem = NB'(t - den2);
                n_q   = MB'({p_q, 1'b0} + 2'd2);
            end else if (t >= den1) begin
                n_rem = NB'(t - den1);
                n_q   = MB'({p_q, 1'b0} + 1'b1);
            end else begin
                n_rem = t[NB-1:0];
                n_q   = {p_q[MB-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[i] <= n_rem;
                r_num[i] <= p_num;
                r_den[i] <= p_den;
                r_q[i]   <= n_q;
                r_mag[i] <= p_mag;
                r_neg[i] <= p_neg;
            end
        end
    end

    // ties go toward plus infinity
    logic          up;
    logic [MB:0]   qr;
    always_comb begin
        if (r_neg[MB-1]) begin
            up = {r_rem[MB-1], 1'b0} > {1'b0, r_den[MB-1]};
        end else begin
            up = {r_rem[MB-1], 1'b0} >= {1'b0, r_den[MB-1]};
        end
        qr = {1'b0, r_q[MB-1]} + (MB+1)'(up);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_off <= r_neg[MB-1] ? -$signed(qr) : $signed(qr);
        end
    end

    assign o_off = r_off;

endmodule

`default_nettype wire

[rtl/core/segment_intersection.sv]
// segment intersection: two 2d segments in, crossing status and point out
//
// i_pts carries one segment pair per transaction (endpoints a, b of the
// first segment and c, d of the second). o_res returns exactly one result
// per pair, in order: hit, status (found, zero length, no crossing, outside
// the first segment) and the crossing point with FRAC_BITS fraction bits,
// zero unless hit.
// Throughput is one pair per cycle while i_pts.ready is high. Between
// acceptance and o_res.valid a pair passes four stages of differences,
// cross products and sign tests, one stage per bit of the scaled
// direction in the shift-and-subtract divider, one rounding stage and
// the output register.
// Reset clears every valid bit; no result is pending afterwards.
// When the receiver stalls, the result holds on o_res and one more result
// goes to a skid register; only then does the pipeline freeze and
// i_pts.ready drop, and nothing is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none

module segment_intersection #(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 8
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    segi_in_if.sink    i_pts,
    segi_out_if.source o_res
);

    localparam int W  = COORD_BITS;
    localparam int DW = W + 1;
    localparam int PW = 2 * DW;
    localparam int NB = PW + 2;
    localparam int MB = W + FRAC_BITS;
    localparam int LAT = MB + 1;
    localparam int OB = segi_pkg::OUT_BITS;
    localparam int XW = (W + FRAC_BITS + 2 > OB) ? W + FRAC_BITS + 2 : OB;

    logic en;
    logic r_skd_vld;
    assign en          = !r_skd_vld;
    assign i_pts.ready = en;

    // stage 1: differences from a, zero-length test
    logic                 r1_vld, r1_zero;
    logic signed [W-1:0]  r1_ax, r1_ay;
    logic signed [DW-1:0] r1_bx, r1_by, r1_cx, r1_cy, r1_dx, r1_dy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (en) begin
            r1_vld <= i_pts.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_zero <= (i_pts.point_a_x == i_pts.point_b_x && i_pts.point_a_y == i_pts.point_b_y)
                    || (i_pts.point_c_x == i_pts.point_d_x && i_pts.point_c_y == i_pts.point_d_y);
            r1_ax <= i_pts.point_a_x;
            r1_ay <= i_pts.point_a_y;
            r1_bx <= DW'(i_pts.point_b_x) - DW'(i_pts.point_a_x);
            r1_by <= DW'(i_pts.point_b_y) - DW'(i_pts.point_a_y);
            r1_cx <= DW'(i_pts.point_c_x) - DW'(i_pts.point_a_x);
            r1_cy <= DW'(i_pts.point_c_y) - DW'(i_pts.point_a_y);
            r1_dx <= DW'(i_pts.point_d_x) - DW'(i_pts.point_a_x);
            r1_dy <= DW'(i_pts.point_d_y) - DW'(i_pts.point_a_y);
        end
    end

    // stage 2: products
    logic                 r2_vld, r2_zero;
    logic signed [W-1:0]  r2_ax, r2_ay;
    logic signed [DW-1:0] r2_bx, r2_by;
    logic signed [PW-1:0] r2_bxcy, r2_bycx, r2_bxdy, r2_bydx, r2_cxdy, r2_cydx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (en) begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_zero <= r1_zero;
            r2_ax   <= r1_ax;
            r2_ay   <= r1_ay;
            r2_bx   <= r1_bx;
            r2_by   <= r1_by;
            r2_bxcy <= PW'(r1_bx) * PW'(r1_cy);
            r2_bycx <= PW'(r1_by) * PW'(r1_cx);
            r2_bxdy <= PW'(r1_bx) * PW'(r1_dy);
            r2_bydx <= PW'(r1_by) * PW'(r1_dx);
            r2_cxdy <= PW'(r1_cx) * PW'(r1_dy);
            r2_cydx <= PW'(r1_cy) * PW'(r1_dx);
        end
    end

    // stage 3: cross products and denominator
    logic                   r3_vld, r3_zero;
    logic signed [W-1:0]    r3_ax, r3_ay;
    logic signed [DW-1:0]   r3_bx, r3_by;
    logic signed [PW:0]     r3_sc, r3_sd, r3_num;
    logic signed [PW+1:0]   r3_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else if (en) begin
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_zero <= r2_zero;
            r3_ax   <= r2_ax;
            r3_ay   <= r2_ay;
            r3_bx   <= r2_bx;
            r3_by   <= r2_by;
            r3_sc   <= (PW+1)'(r2_bxcy) - (PW+1)'(r2_bycx);
            r3_sd   <= (PW+1)'(r2_bxdy) - (PW+1)'(r2_bydx);
            r3_num  <= (PW+1)'(r2_cxdy) - (PW+1)'(r2_cydx);
            r3_den  <= ((PW+2)'(r2_bxdy) - (PW+2)'(r2_bydx))
                     - ((PW+2)'(r2_bxcy) - (PW+2)'(r2_bycx));
        end
    end

    // stage 4: status decision, divider operands
    logic                  r4_vld;
    logic [1:0]            r4_status;
    logic signed [W-1:0]   r4_ax, r4_ay;
    logic [NB-1:0]         r4_num, r4_den;
    logic [MB-1:0]         r4_magx, r4_magy;
    logic                  r4_negx, r4_negy;

    logic signed [NB-1:0]  s_num, s_den;
    logic [1:0]            n_status;
    logic signed [DW-1:0]  abs_bx, abs_by;

    always_comb begin
        if (r3_den < 0) begin
            s_den = -NB'(r3_den);
            s_num = -NB'(r3_num);
        end else begin
            s_den = NB'(r3_den);
            s_num = NB'(r3_num);
        end
        abs_bx = (r3_bx < 0) ? -r3_bx : r3_bx;
        abs_by = (r3_by < 0) ? -r3_by : r3_by;
        priority if (r3_zero) begin
            n_status = segi_pkg::ST_ZERO;
        end else if ((r3_sc < 0) == (r3_sd < 0)) begin
            n_status = segi_pkg::ST_NOCROSS;
        end else if (s_num < 0 || s_num > s_den) begin
            n_status = segi_pkg::ST_OUTSIDE;
        end else begin
            n_status = segi_pkg::ST_FOUND;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else if (en) begin
            r4_vld <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_status <= n_status;
            r4_ax     <= r3_ax;
            r4_ay     <= r3_ay;
            r4_num    <= s_num;
            r4_den    <= s_den;
            r4_magx   <= MB'(abs_bx[W-1:0]) << FRAC_BITS;
            r4_magy   <= MB'(abs_by[W-1:0]) << FRAC_BITS;
            r4_negx   <= r3_bx < 0;
            r4_negy   <= r3_by < 0;
        end
    end

    // dividers, one per coordinate
    logic signed [MB:0] off_x, off_y;

    segi_muldiv #(.NB(NB), .MB(MB)) u_div_x (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r4_num),
        .i_den (r4_den),
        .i_mag (r4_magx),
        .i_neg (r4_negx),
        .o_off (off_x)
    );

    segi_muldiv #(.NB(NB), .MB(MB)) u_div_y (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r4_num),
        .i_den (r4_den),
        .i_mag (r4_magy),
        .i_neg (r4_negy),
        .o_off (off_y)
    );

    // sideband alongside the dividers
    logic                r_sb_vld [LAT];
    logic [1:0]          r_sb_st  [LAT];
    logic signed [W-1:0] r_sb_ax  [LAT];
    logic signed [W-1:0] r_sb_ay  [LAT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LAT; k++) begin
                r_sb_vld[k] <= 1'b0;
            end
        end else if (en) begin
            r_sb_vld[0] <= r4_vld;
            for (int k = 1; k < LAT; k++) begin
                r_sb_vld[k] <= r_sb_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sb_st[0] <= r4_status;
            r_sb_ax[0] <= r4_ax;
            r_sb_ay[0] <= r4_ay;
            for (int k = 1; k < LAT; k++) begin
                r_sb_st[k] <= r_sb_st[k-1];
                r_sb_ax[k] <= r_sb_ax[k-1];
                r_sb_ay[k] <= r_sb_ay[k-1];
            end
        end
    end

    // final point and output staging
    logic                  m_vld, m_hit;
    logic [1:0]            m_st;
    logic signed [XW-1:0]  m_x, m_y;
    logic signed [OB-1:0]  m_cx, m_cy;

    always_comb begin
        m_vld = r_sb_vld[LAT-1];
        m_st  = r_sb_st[LAT-1];
        m_hit = m_st == segi_pkg::ST_FOUND;
        m_x   = (XW'(r_sb_ax[LAT-1]) <<< FRAC_BITS) + XW'(off_x);
        m_y   = (XW'(r_sb_ay[LAT-1]) <<< FRAC_BITS) + XW'(off_y);
        m_cx  = m_hit ? m_x[OB-1:0] : '0;
        m_cy  = m_hit ? m_y[OB-1:0] : '0;
    end

    logic                 r_out_vld;
    logic                 r_out_hit, r_skd_hit;
    logic [1:0]           r_out_st, r_skd_st;
    logic signed [OB-1:0] r_out_x, r_out_y, r_skd_x, r_skd_y;
    logic                 out_free, load_out_new, load_out_skd, load_skd;

    assign out_free     = !r_out_vld || o_res.ready;
    assign load_out_skd = out_free && r_skd_vld;
    assign load_out_new = out_free && !r_skd_vld && en && m_vld;
    assign load_skd     = !out_free && en && m_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            r_skd_vld <= 1'b0;
        end else begin
            if (out_free) begin
                r_out_vld <= r_skd_vld || (en && m_vld);
                r_skd_vld <= 1'b0;
            end else if (load_skd) begin
                r_skd_vld <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out_skd) begin
            r_out_hit <= r_skd_hit;
            r_out_st  <= r_skd_st;
            r_out_x   <= r_skd_x;
            r_out_y   <= r_skd_y;
        end else if (load_out_new) begin
            r_out_hit <= m_hit;
            r_out_st  <= m_st;
            r_out_x   <= m_cx;
            r_out_y   <= m_cy;
        end
        if (load_skd) begin
            r_skd_hit <= m_hit;
            r_skd_st  <= m_st;
            r_skd_x   <= m_cx;
            r_skd_y   <= m_cy;
        end
    end

    assign o_res.valid   = r_out_vld;
    assign o_res.hit     = r_out_hit;
    assign o_res.status  = r_out_st;
    assign o_res.cross_x = r_out_x;
    assign o_res.cross_y = r_out_y;

endmodule

`default_nettype wire

[rtl/core/segi_chk.sv]
// port-level assertions for the segment intersection block, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module segi_chk (
    input wire                          i_clk,
    input wire                          i_rst_n,
    input wire                          i_out_valid,
    input wire                          i_out_ready,
    input wire                          i_hit,
    input wire [1:0]                    i_status,
    input wire [segi_pkg::OUT_BITS-1:0] i_cross_x,
    input wire [segi_pkg::OUT_BITS-1:0] i_cross_y
);

    // nothing pending straight after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // hit flag agrees with the status code
    a_hit_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_hit == (i_status == segi_pkg::ST_FOUND)))
        else $error("hit does not match status");

    // no point reported on a miss
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_hit) |-> (i_cross_x == '0 && i_cross_y == '0))
        else $error("nonzero point on a miss");

    // a stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_hit)
            && $stable(i_status) && $stable(i_cross_x) && $stable(i_cross_y)))
        else $error("stalled result changed");

endmodule

bind segment_intersection segi_chk u_segi_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_hit       (o_res.hit),
    .i_status    (o_res.status),
    .i_cross_x   (o_res.cross_x),
    .i_cross_y   (o_res.cross_y)
);

`default_nettype wire
